FILE: rtl/core/dle_frame_receiver_bcc_macros.svh
// ----------------------------------------------------------------------------
// DLE frame receiver assertion macros
// Assertion shorthands that expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DLE_FRAME_RECEIVER_BCC_MACROS_SVH
`define DLE_FRAME_RECEIVER_BCC_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfr assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfr assertion failed");

`else

`define DFR_ASSERT_IMPL(lbl, ante, cons)
`define DFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/dfr_pkg.sv
// ----------------------------------------------------------------------------
// DLE frame receiver package
// Shared constants, codes and item types of the DLE frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int MAX_PAYLOAD_DEF = 255;

  // Reset values of the framing characters.
  localparam logic [7:0] CHR_DLE = 8'h10;
  localparam logic [7:0] CHR_STX = 8'h02;
  localparam logic [7:0] CHR_ETX = 8'h03;

  // Configuration register indexes.
  localparam logic [1:0] REG_ESCAPE = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;

  // Commands.
  localparam logic [1:0] CMD_RX      = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ACCEPT    = 3'd1,
    EV_BCC_BAD   = 3'd2,
    EV_RING_FULL = 3'd3,
    EV_TOO_LONG  = 3'd4,
    EV_ABORT     = 3'd5
  } event_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] read_data;
    logic [7:0] oldest_length;
    logic [3:0] frames_waiting;
  } out_item_t;

  typedef struct packed {
    logic [7:0] escape_code;
    logic [7:0] start_code;
    logic [7:0] end_code;
  } codes_t;

  // What one line byte asks of the frame store and the ring.
  typedef struct packed {
    event_t     ev;
    logic       byte_we;
    logic [7:0] byte_data;
    logic [7:0] byte_off;
    logic       commit;
    logic [7:0] commit_len;
  } rx_action_t;

endpackage

FILE: rtl/core/dle_frame_receiver_bcc.sv
// ----------------------------------------------------------------------------
// DLE frame receiver with XOR BCC
// Unstuffs DLE framed bytes into a ring of frame slots kept in memory and
// serves reads and releases of the oldest committed frame.
// ----------------------------------------------------------------------------
// Timing: an accepted item writes the store and is registered; in S_RD the
//   frame and length memories register their reads, and in S_CAP the
//   output register is loaded once the output is free.
// Flow: a new item is taken only in S_IDLE, after the last result has been
//   loaded into the output register, so a stalled output holds off the input.
// Reset: rst clears the framing phase, ring pointers and counts and restores
//   the default codes; the memories are not cleared and no clearing pass is needed.
module dle_frame_receiver_bcc #(
  parameter int NUM_SLOTS   = dfr_pkg::NUM_SLOTS_DEF,
  parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dfr_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dfr_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

`include "dle_frame_receiver_bcc_macros.svh"

  localparam int DEPTH = NUM_SLOTS * MAX_PAYLOAD;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(NUM_SLOTS);
  localparam int UW    = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_CAP  = 3'b100
  } state_t;

  state_t              state;
  dfr_pkg::codes_t     codes;
  dfr_pkg::rx_action_t act;
  dfr_pkg::event_t     ev_q;
  logic [1:0]          cmd_q;
  logic [7:0]          idx_q;
  logic [SW-1:0]       write_slot;
  logic [SW-1:0]       read_slot;
  logic [AW-1:0]       write_base;
  logic [AW-1:0]       read_base;
  logic [UW-1:0]       slots_used;
  logic                ring_full;
  logic                in_acc;
  logic                rx_step;
  logic [AW-1:0]       byte_waddr;
  logic [AW-1:0]       byte_raddr;
  logic [AW:0]         waddr_sum;
  logic [AW:0]         raddr_sum;
  logic [7:0]          byte_rdata;
  logic [7:0]          len_rdata;
  logic                read_hit;
  logic                out_free;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign rx_step   = in_acc && (in_data.cmd == dfr_pkg::CMD_RX);
  assign ring_full = (slots_used >= UW'(NUM_SLOTS));
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.escape_code <= dfr_pkg::CHR_DLE;
      codes.start_code  <= dfr_pkg::CHR_STX;
      codes.end_code    <= dfr_pkg::CHR_ETX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfr_pkg::REG_ESCAPE: codes.escape_code <= cfg_wdata;
        dfr_pkg::REG_START:  codes.start_code  <= cfg_wdata;
        dfr_pkg::REG_END:    codes.end_code    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dfr_rx_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (rx_step),
    .rx_byte   (in_data.rx_byte),
    .codes     (codes),
    .ring_full (ring_full),
    .act       (act)
  );

  // Payload offsets stay below MAX_PAYLOAD wherever the address is used.
  assign waddr_sum  = {1'b0, write_base} + (AW+1)'(act.byte_off);
  assign byte_waddr = waddr_sum[AW-1:0];
  assign raddr_sum  = (idx_q < 8'(MAX_PAYLOAD)) ?
                      ({1'b0, read_base} + (AW+1)'(idx_q)) : {1'b0, read_base};
  assign byte_raddr = raddr_sum[AW-1:0];

  dfr_store #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_store (
    .clk        (clk),
    .byte_we    (act.byte_we),
    .byte_waddr (byte_waddr),
    .byte_wdata (act.byte_data),
    .byte_raddr (byte_raddr),
    .byte_rdata (byte_rdata),
    .len_we     (act.commit),
    .len_waddr  (write_slot),
    .len_wdata  (act.commit_len),
    .len_raddr  (read_slot),
    .len_rdata  (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q <= in_data.cmd;
      idx_q <= in_data.read_index;
      ev_q  <= rx_step ? act.ev : dfr_pkg::EV_NONE;
    end
  end

  // Ring pointers; a commit and a release never come from the same item.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      write_base <= '0;
      read_slot  <= '0;
      read_base  <= '0;
      slots_used <= '0;
    end else if (in_acc) begin
      if (act.commit) begin
        if (write_slot == SW'(NUM_SLOTS - 1)) begin
          write_slot <= '0;
          write_base <= '0;
        end else begin
          write_slot <= write_slot + SW'(1);
          write_base <= write_base + AW'(MAX_PAYLOAD);
        end
        slots_used <= slots_used + UW'(1);
      end else if (in_data.cmd == dfr_pkg::CMD_RELEASE && slots_used != '0) begin
        if (read_slot == SW'(NUM_SLOTS - 1)) begin
          read_slot <= '0;
          read_base <= '0;
        end else begin
          read_slot <= read_slot + SW'(1);
          read_base <= read_base + AW'(MAX_PAYLOAD);
        end
        slots_used <= slots_used - UW'(1);
      end
    end
  end

  assign read_hit = (cmd_q == dfr_pkg::CMD_READ) && (slots_used != '0) &&
                    (idx_q < len_rdata) && (idx_q < 8'(MAX_PAYLOAD));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CAP;
        end
        S_CAP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CAP && out_free) begin
      out_data.event_code     <= ev_q;
      out_data.read_data      <= read_hit ? byte_rdata : 8'd0;
      out_data.oldest_length  <= (slots_used != '0) ? len_rdata : 8'd0;
      out_data.frames_waiting <= 4'(slots_used);
    end
  end

  `DFR_ASSERT_IMPL(a_used_bound, 1'b1, slots_used <= UW'(NUM_SLOTS))
  `DFR_ASSERT_IMPL(a_commit_room, act.commit, !ring_full && act.ev == dfr_pkg::EV_ACCEPT)
  `DFR_ASSERT_NEXT(a_accept_reads, in_acc, state == S_RD && !in_ready)
  `DFR_ASSERT_NEXT(a_cap_delivers, state == S_CAP && out_free, out_valid && state == S_IDLE)

endmodule

FILE: rtl/core/dfr_store.sv
// ----------------------------------------------------------------------------
// DLE frame receiver storage
// Frame byte memory and slot length memory, each one write and one
// registered read port.
// ----------------------------------------------------------------------------
module dfr_store #(
  parameter int NUM_SLOTS   = dfr_pkg::NUM_SLOTS_DEF,
  parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF,
  localparam int DEPTH = NUM_SLOTS * MAX_PAYLOAD,
  localparam int AW    = $clog2(DEPTH),
  localparam int SW    = $clog2(NUM_SLOTS)
) (
  input  logic          clk,
  input  logic          byte_we,
  input  logic [AW-1:0] byte_waddr,
  input  logic [7:0]    byte_wdata,
  input  logic [AW-1:0] byte_raddr,
  output logic [7:0]    byte_rdata,
  input  logic          len_we,
  input  logic [SW-1:0] len_waddr,
  input  logic [7:0]    len_wdata,
  input  logic [SW-1:0] len_raddr,
  output logic [7:0]    len_rdata
);

  logic [7:0] frame_mem [DEPTH];
  logic [7:0] len_mem   [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (byte_we) begin
      frame_mem[byte_waddr] <= byte_wdata;
    end
    byte_rdata <= frame_mem[byte_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rdata <= len_mem[len_raddr];
  end

endmodule

FILE: rtl/core/dfr_rx_parser.sv
// ----------------------------------------------------------------------------
// DLE frame receiver line parser
// Tracks the framing phase, the running BCC and the payload count, and
// turns each line byte into any store write, commit and event it calls for.
// ----------------------------------------------------------------------------
module dfr_rx_parser #(
  parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  dfr_pkg::codes_t     codes,
  input  logic                ring_full,
  output dfr_pkg::rx_action_t act
);

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_WAIT_START = 5'b00010,
    PH_DATA       = 5'b00100,
    PH_AFTER_ESC  = 5'b01000,
    PH_WAIT_BCC   = 5'b10000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] bcc, bcc_next;
  logic [7:0] count, count_next;
  logic       lost, lost_next;
  logic       do_store;
  logic       do_clear;

  always_comb begin
    phase_next     = phase;
    bcc_next       = bcc;
    count_next     = count;
    lost_next      = lost;
    do_store       = 1'b0;
    do_clear       = 1'b0;
    act            = '0;
    act.ev         = dfr_pkg::EV_NONE;
    act.byte_data  = rx_byte;
    act.byte_off   = count;
    act.commit_len = count;
    if (step) begin
      unique case (phase)
        PH_IDLE: begin
          do_clear = 1'b1;
          if (rx_byte == codes.escape_code) begin
            phase_next = PH_WAIT_START;
          end
        end
        PH_WAIT_START: begin
          phase_next = (rx_byte == codes.start_code) ? PH_DATA : PH_IDLE;
        end
        PH_DATA: begin
          if (rx_byte == codes.escape_code) begin
            phase_next = PH_AFTER_ESC;
          end else begin
            do_store = 1'b1;
          end
        end
        PH_AFTER_ESC: begin
          // Escape is tested first, then end, then start, when codes coincide.
          if (rx_byte == codes.escape_code) begin
            do_store = 1'b1;
          end else if (rx_byte == codes.end_code) begin
            bcc_next   = bcc ^ rx_byte;
            phase_next = PH_WAIT_BCC;
          end else if (rx_byte == codes.start_code) begin
            do_clear   = 1'b1;
            phase_next = PH_DATA;
          end else begin
            do_clear   = 1'b1;
            phase_next = PH_IDLE;
            act.ev     = dfr_pkg::EV_ABORT;
          end
        end
        PH_WAIT_BCC: begin
          if (rx_byte != bcc) begin
            act.ev = dfr_pkg::EV_BCC_BAD;
          end else if (ring_full || lost) begin
            act.ev = dfr_pkg::EV_RING_FULL;
          end else begin
            act.ev     = dfr_pkg::EV_ACCEPT;
            act.commit = 1'b1;
          end
          do_clear   = 1'b1;
          phase_next = PH_IDLE;
        end
        default: begin
          do_clear   = 1'b1;
          phase_next = PH_IDLE;
        end
      endcase

      if (do_store) begin
        if (count >= 8'(MAX_PAYLOAD)) begin
          do_clear   = 1'b1;
          phase_next = PH_IDLE;
          act.ev     = dfr_pkg::EV_TOO_LONG;
        end else begin
          // With the ring full the byte is counted but cannot be kept.
          act.byte_we = !ring_full;
          lost_next   = lost | ring_full;
          bcc_next    = bcc ^ rx_byte;
          count_next  = count + 8'd1;
          phase_next  = PH_DATA;
        end
      end

      if (do_clear) begin
        bcc_next   = '0;
        count_next = '0;
        lost_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bcc   <= '0;
      count <= '0;
      lost  <= 1'b0;
    end else begin
      phase <= phase_next;
      bcc   <= bcc_next;
      count <= count_next;
      lost  <= lost_next;
    end
  end

endmodule
